// ----- rtl/afc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afc_pkg
// shared types, widths and helpers of the box frustum cull unit
// ----------------------------------------------------------------------------
package afc_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam int NUM_PLANES = 6;
    localparam int NUM_REGS   = 8;
    localparam int REG_W      = 64;
    localparam int HALF_W     = REG_W / 2;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int CFG_ADDR_W = REG_IDX_W + 1;

    // plane components and corner coordinates
    localparam int NW     = COORD_WIDTH + 1;
    localparam int PW     = 2 * NW;
    localparam int DW     = NW + FRAC_BITS;
    localparam int SUM_W  = ((PW > DW) ? PW : DW) + 2;

    // input transaction layout
    localparam int CTR_W       = 32;
    localparam int HALF_IN_W   = 31;
    localparam int CX_LSB      = 0;
    localparam int CY_LSB      = CX_LSB + CTR_W;
    localparam int CZ_LSB      = CY_LSB + CTR_W;
    localparam int HX_LSB      = CZ_LSB + CTR_W;
    localparam int HY_LSB      = HX_LSB + HALF_IN_W;
    localparam int HZ_LSB      = HY_LSB + HALF_IN_W;
    localparam int S_FIELDS_W  = HZ_LSB + HALF_IN_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = 8;

    typedef logic [NUM_REGS-1:0][REG_W-1:0] t_cfg_bank;

    typedef struct packed {
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic signed [NW-1:0] nz;
        logic signed [NW-1:0] d;
    } t_plane;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] ctr_x;
        logic signed [COORD_WIDTH-1:0] ctr_y;
        logic signed [COORD_WIDTH-1:0] ctr_z;
        logic [COORD_WIDTH-2:0]        half_x;
        logic [COORD_WIDTH-2:0]        half_y;
        logic [COORD_WIDTH-2:0]        half_z;
    } t_box;

    typedef struct packed {
        logic valid;
        logic vis;
    } t_flow;

    // component c (x, y, z, w) of matrix row r, sign extended
    function automatic logic signed [NW-1:0] row_elem(t_cfg_bank cfg, int unsigned r,
                                                      int unsigned c);
        logic [REG_W-1:0]  w;
        logic [HALF_W-1:0] h;
        w = cfg[REG_IDX_W'(r * 2 + (c >> 1))];
        h = ((c & 1) != 0) ? w[REG_W-1:HALF_W] : w[HALF_W-1:0];
        return NW'(signed'(h[COORD_WIDTH-1:0]));
    endfunction

    // plane p: row3 + row(p/2) for even p, row3 - row(p/2) for odd p
    function automatic t_plane plane_of(t_cfg_bank cfg, int unsigned p);
        t_plane               pl;
        logic signed [NW-1:0] v [4];
        logic signed [NW-1:0] a;
        logic signed [NW-1:0] b;
        for (int unsigned c = 0; c < 4; c++) begin
            a = row_elem(cfg, 3, c);
            b = row_elem(cfg, p >> 1, c);
            v[c] = ((p & 1) != 0) ? (a - b) : (a + b);
        end
        pl.nx = v[0];
        pl.ny = v[1];
        pl.nz = v[2];
        pl.d  = v[3];
        return pl;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/aabb_frustum_cull_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_frustum_cull_unit
// box against view frustum visibility test, one box per clock unless stalled
//
// input stream s_axis carries one box per transaction: center x, y, z and
// half extents x, y, z. output stream m_axis returns one visible bit per
// box, in order. the user must write the four view-projection rows through
// the cfg port (index 0..7, two values per register) only while no box is
// in flight, not enforced by the block; writes to other indexes are dropped.
// a box passes an input register, then a chain of six plane cells of three
// stages each, then the output register that drives m_axis_tvalid.
// throughput is one box per cycle while the chain is not held.
// when the receiver stalls, one result goes into a skid entry; with that
// entry full the whole chain holds and s_axis_tready drops until the
// output drains. reset clears the matrix rows to zero and empties the chain.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_unit import afc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [REG_W-1:0]      i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // center_x, center_y, center_z, half_x, half_y, half_z
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata    // visible
);

    t_cfg_bank r_cfg;
    t_plane    r_plane [NUM_PLANES];
    t_box      r_in_box;
    t_flow     r_in_flow;
    t_box      w_box   [NUM_PLANES+1];
    t_flow     w_flow  [NUM_PLANES+1];
    logic      w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en && (i_cfg_addr < CFG_ADDR_W'(NUM_REGS))) begin
            r_cfg[i_cfg_addr[REG_IDX_W-1:0]] <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            r_plane[p] <= plane_of(r_cfg, p);
        end
    end

    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_flow <= '0;
        end else if (w_en) begin
            r_in_flow.valid <= s_axis_tvalid;
            r_in_flow.vis   <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_box.ctr_x  <= s_axis_tdata[CX_LSB +: COORD_WIDTH];
            r_in_box.ctr_y  <= s_axis_tdata[CY_LSB +: COORD_WIDTH];
            r_in_box.ctr_z  <= s_axis_tdata[CZ_LSB +: COORD_WIDTH];
            r_in_box.half_x <= s_axis_tdata[HX_LSB +: COORD_WIDTH-1];
            r_in_box.half_y <= s_axis_tdata[HY_LSB +: COORD_WIDTH-1];
            r_in_box.half_z <= s_axis_tdata[HZ_LSB +: COORD_WIDTH-1];
        end
    end

    assign w_box[0]  = r_in_box;
    assign w_flow[0] = r_in_flow;

    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_cell
        afc_plane_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_plane (r_plane[p]),
            .i_box   (w_box[p]),
            .i_flow  (w_flow[p]),
            .o_box   (w_box[p+1]),
            .o_flow  (w_flow[p+1])
        );
    end

    afc_out_skid u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_flow        (w_flow[NUM_PLANES]),
        .o_chain_en    (w_en),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

`ifndef SYNTHESIS
    a_cfg_unused_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_wr_en && (i_cfg_addr >= CFG_ADDR_W'(NUM_REGS))) |=> $stable(r_cfg))
        else $error("write to unused register index changed the matrix");

    a_last_box_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_box[NUM_PLANES]))
        else $error("cell chain moved while held");
`endif

endmodule
`default_nettype wire

// ----- rtl/afc_plane_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afc_plane_cell
// one plane test: corner select, products, signed sum; box passes on
// ----------------------------------------------------------------------------
module afc_plane_cell import afc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_plane i_plane,
    input  t_box   i_box,
    input  t_flow  i_flow,
    output t_box   o_box,
    output t_flow  o_flow
);

    t_box  r_box1, r_box2, r_box3;
    t_flow r_flow1, r_flow2, r_flow3;

    logic signed [NW-1:0]    r_corner [3];
    logic signed [PW-1:0]    r_prod   [3];

    logic signed [NW-1:0]    w_n      [3];
    logic signed [NW-1:0]    w_ctr    [3];
    logic signed [NW-1:0]    w_half   [3];
    logic signed [NW-1:0]    n_corner [3];
    logic signed [PW-1:0]    n_prod   [3];
    logic signed [SUM_W-1:0] n_sum;

    assign w_n[0]    = i_plane.nx;
    assign w_n[1]    = i_plane.ny;
    assign w_n[2]    = i_plane.nz;
    assign w_ctr[0]  = NW'(i_box.ctr_x);
    assign w_ctr[1]  = NW'(i_box.ctr_y);
    assign w_ctr[2]  = NW'(i_box.ctr_z);
    assign w_half[0] = signed'(NW'(i_box.half_x));
    assign w_half[1] = signed'(NW'(i_box.half_y));
    assign w_half[2] = signed'(NW'(i_box.half_z));

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            // positive normal component takes the far side of the box
            if (!w_n[a][NW-1] && (w_n[a] != '0)) begin
                n_corner[a] = w_ctr[a] + w_half[a];
            end else begin
                n_corner[a] = w_ctr[a] - w_half[a];
            end
            n_prod[a] = PW'(w_n[a]) * PW'(r_corner[a]);
        end
        n_sum = SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]) + SUM_W'(r_prod[2])
              + (SUM_W'(i_plane.d) <<< FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow1 <= '0;
            r_flow2 <= '0;
            r_flow3 <= '0;
        end else if (i_en) begin
            r_flow1       <= i_flow;
            r_flow2       <= r_flow1;
            r_flow3.valid <= r_flow2.valid;
            r_flow3.vis   <= r_flow2.vis & ~n_sum[SUM_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_box1 <= i_box;
            r_box2 <= r_box1;
            r_box3 <= r_box2;
            for (int a = 0; a < 3; a++) begin
                r_corner[a] <= n_corner[a];
                r_prod[a]   <= n_prod[a];
            end
        end
    end

    assign o_box  = r_box3;
    assign o_flow = r_flow3;

endmodule
`default_nettype wire

// ----- rtl/afc_out_skid.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afc_out_skid
// output register with one skid entry; stalls the cell chain when full
// ----------------------------------------------------------------------------
module afc_out_skid import afc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_flow                i_flow,
    output logic                 o_chain_en,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // visible
);

    logic r_out_valid;
    logic r_out_vis;
    logic r_skid_valid;
    logic r_skid_vis;
    logic w_take;

    assign w_take = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out_vis    <= r_skid_vis;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_flow.valid;
                r_out_vis   <= i_flow.vis;
            end
        end else if (i_flow.valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
            r_skid_vis   <= i_flow.vis;
        end
    end

    assign o_chain_en    = !r_skid_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_out_vis);

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !m_axis_tready && i_flow.valid))
        else $error("skid filled without a stalled output");
`endif

endmodule
`default_nettype wire
